@@ rtl/core/slte_pkg.sv @@
// ----------------------------------------------------------------------------
// slte_pkg
// shared types and constants of the sprite list tile expander
// ----------------------------------------------------------------------------
`default_nettype none

package slte_pkg;

  // request action codes
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_STEP  = 2'd2
  } action_t;

  // sprite list depth
  localparam int unsigned LIST_ENTRIES_DEF = 256;

  // field widths
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned COLOR_W = 5;
  localparam int unsigned TILE_W  = 4;

  // attribute word layout
  localparam int unsigned ATTR_FLIPX_BIT = 5;
  localparam int unsigned ATTR_FLIPY_BIT = 6;
  localparam logic [7:0]  ATTR_END_MARK  = 8'hff;

endpackage : slte_pkg

`default_nettype wire

@@ rtl/core/sprite_list_tile_expander.sv @@
// ----------------------------------------------------------------------------
// sprite_list_tile_expander
// expands sprite list entries into 16x16 tile draws, one tile per step request
// ----------------------------------------------------------------------------
// an accepted request's result is registered and shows on the out_ side in the cycle after it is taken
// throughput: one request per cycle; every request yields exactly one result
// the result register frees on the same edge it is taken, so in_ready stays
// high while out_ready is high
// reset: rst_n synchronous, active low; clears the list, the end flag, the
// active sprite and the result valid flag (the result payload is not reset)
`default_nettype none

module sprite_list_tile_expander
  import slte_pkg::*;
#(
  parameter int unsigned LIST_ENTRIES = LIST_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_action,
  input  wire logic [WORD_W-1:0]    in_x_position,
  input  wire logic [WORD_W-1:0]    in_y_position,
  input  wire logic [WORD_W-1:0]    in_tile_number,
  input  wire logic [WORD_W-1:0]    in_attributes,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_tile_valid,
  output logic [POS_W-1:0]          out_screen_x,
  output logic [POS_W-1:0]          out_screen_y,
  output logic [POS_W-1:0]          out_tile_code,
  output logic [COLOR_W-1:0]        out_colour,
  output logic                      out_flip_x,
  output logic                      out_flip_y,
  output logic                      out_last_tile,
  output logic                      out_list_end
);

  // entry counter must be able to hold the list depth itself
  localparam int unsigned CNT_W = $clog2(LIST_ENTRIES + 1);

  // --------------------------------------------------------------------------
  // sprite state
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]   base_x_r, base_x_nxt;
  logic [POS_W-1:0]   base_y_r, base_y_nxt;
  logic [WORD_W-1:0]  base_code_r, base_code_nxt;
  logic [WORD_W-1:0]  sprite_attr_r, sprite_attr_nxt;
  logic [TILE_W-1:0]  column_r, column_nxt;
  logic [TILE_W-1:0]  row_r, row_nxt;
  logic               active_r, active_nxt;
  logic [CNT_W-1:0]   entry_count_r, entry_count_nxt;
  logic               ended_r, ended_nxt;

  // result register
  logic               out_valid_r;
  logic               tile_valid_r, tile_valid_nxt;
  logic [POS_W-1:0]   screen_x_r, screen_x_nxt;
  logic [POS_W-1:0]   screen_y_r, screen_y_nxt;
  logic [POS_W-1:0]   tile_code_r, tile_code_nxt;
  logic [COLOR_W-1:0] colour_r, colour_nxt;
  logic               flip_x_r, flip_x_nxt;
  logic               flip_y_r, flip_y_nxt;
  logic               last_tile_r, last_tile_nxt;

  logic               in_fire;

  // request taken whenever the result slot is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // decode of the stored sprite
  // --------------------------------------------------------------------------
  logic [TILE_W-1:0] cur_wide, cur_high;
  logic              cur_fx, cur_fy;
  logic              cur_last, row_done;
  logic [POS_W-1:0]  col_ofs, row_ofs;

  assign cur_wide = sprite_attr_r[11:8];
  assign cur_high = sprite_attr_r[15:12];
  assign cur_fx   = sprite_attr_r[ATTR_FLIPX_BIT];
  assign cur_fy   = sprite_attr_r[ATTR_FLIPY_BIT];
  assign cur_last = (column_r == cur_wide) && (row_r == cur_high);
  assign row_done = (column_r >= cur_wide);
  // 16 * column and 16 * row, zero extended
  assign col_ofs  = {{(POS_W-TILE_W-4){1'b0}}, column_r, 4'b0000};
  assign row_ofs  = {{(POS_W-TILE_W-4){1'b0}}, row_r, 4'b0000};

  // --------------------------------------------------------------------------
  // decode of an incoming entry
  // --------------------------------------------------------------------------
  logic [TILE_W-1:0] in_wide, in_high;
  logic              in_end_mark, list_full;
  logic [POS_W-1:0]  in_x_ext, in_y_ext;

  assign in_wide     = in_attributes[11:8];
  assign in_high     = in_attributes[15:12];
  assign in_end_mark = (in_attributes[15:8] == ATTR_END_MARK);
  assign list_full   = (entry_count_r >= CNT_W'(LIST_ENTRIES));
  assign in_x_ext    = {1'b0, in_x_position};
  assign in_y_ext    = {1'b0, in_y_position};

  // --------------------------------------------------------------------------
  // next state and result, one pass per request
  // --------------------------------------------------------------------------
  always_comb begin
    base_x_nxt      = base_x_r;
    base_y_nxt      = base_y_r;
    base_code_nxt   = base_code_r;
    sprite_attr_nxt = sprite_attr_r;
    column_nxt      = column_r;
    row_nxt         = row_r;
    active_nxt      = active_r;
    entry_count_nxt = entry_count_r;
    ended_nxt       = ended_r;

    // non-tile results carry zeros
    tile_valid_nxt  = 1'b0;
    screen_x_nxt    = '0;
    screen_y_nxt    = '0;
    tile_code_nxt   = '0;
    colour_nxt      = '0;
    flip_x_nxt      = 1'b0;
    flip_y_nxt      = 1'b0;
    last_tile_nxt   = 1'b0;

    unique case (in_action)
      ACT_START: begin
        entry_count_nxt = '0;
        ended_nxt       = 1'b0;
        active_nxt      = 1'b0;
        column_nxt      = '0;
        row_nxt         = '0;
      end
      ACT_LOAD: begin
        if (!ended_r) begin
          if (in_end_mark || list_full) begin
            // end of list, a sprite in progress keeps its tiles
            ended_nxt = 1'b1;
          end else begin
            // flipped axes start at the far edge
            base_x_nxt = in_attributes[ATTR_FLIPX_BIT]
                       ? in_x_ext + {{(POS_W-TILE_W-4){1'b0}}, in_wide, 4'b0000}
                       : in_x_ext;
            base_y_nxt = in_attributes[ATTR_FLIPY_BIT]
                       ? in_y_ext + {{(POS_W-TILE_W-4){1'b0}}, in_high, 4'b0000}
                       : in_y_ext;
            base_code_nxt   = in_tile_number;
            sprite_attr_nxt = in_attributes;
            column_nxt      = '0;
            row_nxt         = '0;
            active_nxt      = 1'b1;
            entry_count_nxt = entry_count_r + CNT_W'(1);
          end
        end
      end
      ACT_STEP: begin
        if (active_r) begin
          tile_valid_nxt = 1'b1;
          screen_x_nxt   = cur_fx ? base_x_r - col_ofs : base_x_r + col_ofs;
          screen_y_nxt   = cur_fy ? base_y_r - row_ofs : base_y_r + row_ofs;
          tile_code_nxt  = {1'b0, base_code_r}
                         + {{(POS_W-TILE_W){1'b0}}, column_r} + row_ofs;
          colour_nxt     = sprite_attr_r[COLOR_W-1:0];
          flip_x_nxt     = cur_fx;
          flip_y_nxt     = cur_fy;
          last_tile_nxt  = cur_last;
          // advance column first, then row
          if (cur_last) begin
            active_nxt = 1'b0;
            column_nxt = '0;
            row_nxt    = '0;
          end else if (row_done) begin
            column_nxt = '0;
            row_nxt    = row_r + TILE_W'(1);
          end else begin
            column_nxt = column_r + TILE_W'(1);
          end
        end
      end
      default: begin
        // unused action code: no state change, empty result
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      entry_count_r <= '0;
      ended_r       <= 1'b0;
      column_r      <= '0;
      row_r         <= '0;
      sprite_attr_r <= '0;
      base_x_r      <= '0;
      base_y_r      <= '0;
      base_code_r   <= '0;
    end else if (in_fire) begin
      active_r      <= active_nxt;
      entry_count_r <= entry_count_nxt;
      ended_r       <= ended_nxt;
      column_r      <= column_nxt;
      row_r         <= row_nxt;
      sprite_attr_r <= sprite_attr_nxt;
      base_x_r      <= base_x_nxt;
      base_y_r      <= base_y_nxt;
      base_code_r   <= base_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tile_valid_r <= tile_valid_nxt;
      screen_x_r   <= screen_x_nxt;
      screen_y_r   <= screen_y_nxt;
      tile_code_r  <= tile_code_nxt;
      colour_r     <= colour_nxt;
      flip_x_r     <= flip_x_nxt;
      flip_y_r     <= flip_y_nxt;
      last_tile_r  <= last_tile_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tile_valid = tile_valid_r;
  assign out_screen_x   = screen_x_r;
  assign out_screen_y   = screen_y_r;
  assign out_tile_code  = tile_code_r;
  assign out_colour     = colour_r;
  assign out_flip_x     = flip_x_r;
  assign out_flip_y     = flip_y_r;
  assign out_last_tile  = last_tile_r;
  // end flag after the request that produced this result
  assign out_list_end   = ended_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_start_clears_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_action == ACT_START) |=> out_valid && !out_list_end && !out_tile_valid)
    else $error("start request did not clear the end flag");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tile_valid |-> (out_screen_x == '0) && (out_tile_code == '0)
      && !out_last_tile)
    else $error("non-tile result carries data");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(LIST_ENTRIES))
    else $error("entry count beyond list depth");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (column_r == '0) && (row_r == '0))
    else $error("tile counters not cleared without an active sprite");

  a_last_ends_sprite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_action == ACT_STEP) && active_r && cur_last |=> !active_r)
    else $error("sprite still active after its last tile");

endmodule : sprite_list_tile_expander

`default_nettype wire

@@ sim/tile_expand_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_expand_checker
// watches both channels of the sprite list tile expander, predicts the tile
// draw of every accepted request and compares it with the result that comes out
// ----------------------------------------------------------------------------
module tile_expand_checker
  import slte_pkg::*;
#(
  parameter int unsigned LIST_ENTRIES = LIST_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [WORD_W-1:0]  in_x_position,
  input  logic [WORD_W-1:0]  in_y_position,
  input  logic [WORD_W-1:0]  in_tile_number,
  input  logic [WORD_W-1:0]  in_attributes,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_tile_valid,
  input  logic [POS_W-1:0]   out_screen_x,
  input  logic [POS_W-1:0]   out_screen_y,
  input  logic [POS_W-1:0]   out_tile_code,
  input  logic [COLOR_W-1:0] out_colour,
  input  logic               out_flip_x,
  input  logic               out_flip_y,
  input  logic               out_last_tile,
  input  logic               out_list_end,
  output int unsigned        mismatch_count,
  output int unsigned        draws_pending
);

  typedef struct packed {
    logic               tile_valid;
    logic [POS_W-1:0]   screen_x;
    logic [POS_W-1:0]   screen_y;
    logic [POS_W-1:0]   tile_code;
    logic [COLOR_W-1:0] colour;
    logic               flip_x;
    logic               flip_y;
    logic               last_tile;
    logic               list_end;
  } tile_draw_t;

  // predicted sprite state
  logic [POS_W-1:0]  base_x;
  logic [POS_W-1:0]  base_y;
  logic [WORD_W-1:0] base_code;
  logic [WORD_W-1:0] sprite_attr;
  logic [TILE_W-1:0] col_q;
  logic [TILE_W-1:0] row_q;
  logic              sprite_active;
  logic              ended;
  logic [8:0]        entry_count;

  tile_draw_t  draws_q[$];
  int unsigned bad_count = 0;

  assign mismatch_count = bad_count;

  function automatic tile_draw_t expand_request(input logic [1:0] act,
                                                input logic [WORD_W-1:0] xp,
                                                input logic [WORD_W-1:0] yp,
                                                input logic [WORD_W-1:0] num,
                                                input logic [WORD_W-1:0] attr);
    tile_draw_t        d;
    logic [TILE_W-1:0] wide;
    logic [TILE_W-1:0] high;
    logic              fx;
    logic              fy;
    d = '0;
    case (act)
      ACT_START: begin
        entry_count   = '0;
        ended         = 1'b0;
        sprite_active = 1'b0;
        col_q         = '0;
        row_q         = '0;
      end
      ACT_LOAD: begin
        wide = attr[11:8];
        high = attr[15:12];
        if (!ended) begin
          if (attr[15:8] == ATTR_END_MARK || entry_count >= LIST_ENTRIES) begin
            ended = 1'b1;
          end else begin
            // flipped axes start at the far edge
            base_x = {1'b0, xp} + (attr[ATTR_FLIPX_BIT] ? {wide, 4'b0000} : 8'd0);
            base_y = {1'b0, yp} + (attr[ATTR_FLIPY_BIT] ? {high, 4'b0000} : 8'd0);
            base_code     = num;
            sprite_attr   = attr;
            col_q         = '0;
            row_q         = '0;
            sprite_active = 1'b1;
            entry_count   = entry_count + 9'd1;
          end
        end
      end
      ACT_STEP: begin
        if (sprite_active) begin
          wide = sprite_attr[11:8];
          high = sprite_attr[15:12];
          fx   = sprite_attr[ATTR_FLIPX_BIT];
          fy   = sprite_attr[ATTR_FLIPY_BIT];
          d.tile_valid = 1'b1;
          d.screen_x   = fx ? base_x - {col_q, 4'b0000} : base_x + {col_q, 4'b0000};
          d.screen_y   = fy ? base_y - {row_q, 4'b0000} : base_y + {row_q, 4'b0000};
          d.tile_code  = {1'b0, base_code} + col_q + {row_q, 4'b0000};
          d.colour     = sprite_attr[COLOR_W-1:0];
          d.flip_x     = fx;
          d.flip_y     = fy;
          d.last_tile  = (col_q == wide) && (row_q == high);
          if (d.last_tile) begin
            sprite_active = 1'b0;
            col_q         = '0;
            row_q         = '0;
          end else if (col_q >= wide) begin
            col_q = '0;
            row_q = row_q + 4'd1;
          end else begin
            col_q = col_q + 4'd1;
          end
        end
      end
      default: ;
    endcase
    d.list_end = ended;
    return d;
  endfunction

  always @(posedge clk) begin : monitor
    tile_draw_t got;
    tile_draw_t want;
    if (!rst_n) begin
      base_x        = '0;
      base_y        = '0;
      base_code     = '0;
      sprite_attr   = '0;
      col_q         = '0;
      row_q         = '0;
      sprite_active = 1'b0;
      ended         = 1'b0;
      entry_count   = '0;
      draws_q.delete();
      draws_pending <= 0;
    end else begin
      // results come out of a register after their request is taken, so compare before predicting
      if (out_valid && out_ready) begin
        got.tile_valid = out_tile_valid;
        got.screen_x   = out_screen_x;
        got.screen_y   = out_screen_y;
        got.tile_code  = out_tile_code;
        got.colour     = out_colour;
        got.flip_x     = out_flip_x;
        got.flip_y     = out_flip_y;
        got.last_tile  = out_last_tile;
        got.list_end   = out_list_end;
        if (draws_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: result with no request pending: tv=%0d x=%h y=%h code=%h",
                     $realtime, got.tile_valid, got.screen_x, got.screen_y, got.tile_code);
        end else begin
          want = draws_q.pop_front();
          if (got.tile_valid !== want.tile_valid || got.screen_x !== want.screen_x ||
              got.screen_y !== want.screen_y || got.tile_code !== want.tile_code ||
              got.colour !== want.colour || got.flip_x !== want.flip_x ||
              got.flip_y !== want.flip_y || got.last_tile !== want.last_tile ||
              got.list_end !== want.list_end) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: tile draw mismatch", $realtime);
              $display("  exp tv=%0d x=%h y=%h code=%h col=%h fx=%0d fy=%0d last=%0d end=%0d",
                       want.tile_valid, want.screen_x, want.screen_y, want.tile_code,
                       want.colour, want.flip_x, want.flip_y, want.last_tile,
                       want.list_end);
              $display("  got tv=%0d x=%h y=%h code=%h col=%h fx=%0d fy=%0d last=%0d end=%0d",
                       got.tile_valid, got.screen_x, got.screen_y, got.tile_code,
                       got.colour, got.flip_x, got.flip_y, got.last_tile,
                       got.list_end);
            end
          end
        end
      end
      if (in_valid && in_ready)
        draws_q.push_back(expand_request(in_action, in_x_position, in_y_position,
                                         in_tile_number, in_attributes));
      draws_pending <= draws_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives start, load and step requests into the sprite list tile expander,
// with random gaps and stalls on both sides; the checker beside the block
// predicts every tile draw and counts mismatches for the verdict
// ----------------------------------------------------------------------------
module tb_top;
  import slte_pkg::*;

  // action code the block has no name for: does nothing, gives a non-tile
  localparam logic [1:0] ACT_NOP     = 2'd3;
  localparam int unsigned RAND_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_action = '0;
  logic [WORD_W-1:0]   in_x_position = '0;
  logic [WORD_W-1:0]   in_y_position = '0;
  logic [WORD_W-1:0]   in_tile_number = '0;
  logic [WORD_W-1:0]   in_attributes = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_tile_valid;
  logic [POS_W-1:0]    out_screen_x;
  logic [POS_W-1:0]    out_screen_y;
  logic [POS_W-1:0]    out_tile_code;
  logic [COLOR_W-1:0]  out_colour;
  logic                out_flip_x;
  logic                out_flip_y;
  logic                out_last_tile;
  logic                out_list_end;

  int unsigned mismatch_count;
  int unsigned draws_pending;

  // requests sent so far, and the shared knobs for idling and the long stall
  int unsigned req_count = 0;
  int unsigned cycle_count = 0;
  logic        no_idle = 1'b0;
  logic        hold_off_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_list_tile_expander dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_x_position  (in_x_position),
    .in_y_position  (in_y_position),
    .in_tile_number (in_tile_number),
    .in_attributes  (in_attributes),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tile_valid (out_tile_valid),
    .out_screen_x   (out_screen_x),
    .out_screen_y   (out_screen_y),
    .out_tile_code  (out_tile_code),
    .out_colour     (out_colour),
    .out_flip_x     (out_flip_x),
    .out_flip_y     (out_flip_y),
    .out_last_tile  (out_last_tile),
    .out_list_end   (out_list_end)
  );

  tile_expand_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_x_position  (in_x_position),
    .in_y_position  (in_y_position),
    .in_tile_number (in_tile_number),
    .in_attributes  (in_attributes),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tile_valid (out_tile_valid),
    .out_screen_x   (out_screen_x),
    .out_screen_y   (out_screen_y),
    .out_tile_code  (out_tile_code),
    .out_colour     (out_colour),
    .out_flip_x     (out_flip_x),
    .out_flip_y     (out_flip_y),
    .out_last_tile  (out_last_tile),
    .out_list_end   (out_list_end),
    .mismatch_count (mismatch_count),
    .draws_pending  (draws_pending)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    logic        hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 200;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom_range(0, 16'hffff));
  endfunction

  // one request: optional idle gap, then hold valid until the block takes it
  task automatic send_req(input logic [1:0] act, input logic [WORD_W-1:0] xp,
                          input logic [WORD_W-1:0] yp, input logic [WORD_W-1:0] num,
                          input logic [WORD_W-1:0] attr);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_x_position  <= xp;
    in_y_position  <= yp;
    in_tile_number <= num;
    in_attributes  <= attr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req_count++;
  endtask

  // load a sprite of w1+1 by h1+1 tiles with random position, code and low byte;
  // a high byte of all ones would be the end marker, so it is steered off
  task automatic sprite_request(input logic [3:0] w1, input logic [3:0] h1);
    logic [3:0] w_eff;
    w_eff = ({h1, w1} == ATTR_END_MARK) ? 4'd14 : w1;
    send_req(ACT_LOAD, rand_word(), rand_word(), rand_word(),
             {h1, w_eff, 8'(rand_word())} );
  endtask

  initial begin : stimulus
    int         frame_no;
    int         n_sprites;
    int         steps;
    int         shape;
    logic [3:0] w1;
    logic [3:0] h1;
    logic [1:0] noise_act;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // step before any sprite, and the unused action code
    send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    send_req(ACT_NOP, rand_word(), rand_word(), rand_word(), rand_word());
    // 2x2 sprite at the top of every field, both flips, full colour
    send_req(ACT_LOAD, 16'hffff, 16'hffff, 16'hffff, 16'h117f);
    repeat (4) send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    // one step too many: sprite already done
    send_req(ACT_STEP, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    // 1x1 sprite at zero, unused attribute bit set
    send_req(ACT_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0080);
    send_req(ACT_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // sixteen wide, flipped in x, only partly expanded
    send_req(ACT_LOAD, 16'h1234, 16'h0000, 16'hfff0, 16'h0f20);
    repeat (2) send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    // load during a sprite replaces it: sixteen tall, flipped in y
    send_req(ACT_LOAD, 16'h0000, 16'hffff, 16'h0000, 16'hf05f);
    repeat (2) send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    // end marker while a sprite is still going: its tiles keep coming
    send_req(ACT_LOAD, rand_word(), rand_word(), rand_word(), 16'hff00);
    send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    // load after the end is ignored
    send_req(ACT_LOAD, 16'h0040, 16'h0040, 16'h0100, 16'h0000);
    send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    send_req(ACT_NOP, rand_word(), rand_word(), rand_word(), rand_word());
    // new frame drops the active sprite
    send_req(ACT_START, rand_word(), rand_word(), rand_word(), rand_word());
    send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());

    // ---- entry limit frame, with the long result hold-off at its start ----
    send_req(ACT_START, rand_word(), rand_word(), rand_word(), rand_word());
    hold_off_req = 1'b1;
    repeat (LIST_ENTRIES_DEF + 3) begin
      sprite_request(4'($urandom_range(0, 1)), 4'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0)
        send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
    end
    repeat (3) send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());

    // ---- random frames: start, sprites with their steps, end marker ----
    frame_no = 0;
    while (req_count < RAND_ITEMS) begin
      frame_no++;
      // a stretch with no idling on either side
      no_idle = (frame_no >= 4 && frame_no <= 6);
      send_req(ACT_START, rand_word(), rand_word(), rand_word(), rand_word());
      n_sprites = $urandom_range(1, 6);
      repeat (n_sprites) begin
        if ($urandom_range(0, 99) < 10) begin
          // noise request of any action with random fields
          noise_act = 2'($urandom_range(0, 3));
          send_req(noise_act, rand_word(), rand_word(), rand_word(), rand_word());
        end else begin
          if ($urandom_range(0, 9) == 0) begin
            w1 = 4'($urandom_range(0, 15));
            h1 = 4'($urandom_range(0, 15));
          end else begin
            w1 = 4'($urandom_range(0, 3));
            h1 = 4'($urandom_range(0, 3));
          end
          sprite_request(w1, h1);
          steps = (w1 + 1) * (h1 + 1);
          shape = $urandom_range(0, 9);
          // cut short so a later load or start drops the rest, or run one step past
          if (shape == 0)
            steps = $urandom_range(0, steps - 1);
          else if (shape == 1)
            steps = steps + 1;
          if (steps > 48)
            steps = 48;
          repeat (steps)
            send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        send_req(ACT_LOAD, rand_word(), rand_word(), rand_word(),
                 {ATTR_END_MARK, 8'(rand_word())} );
        if ($urandom_range(0, 1) == 0) begin
          sprite_request(4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)));
          send_req(ACT_STEP, rand_word(), rand_word(), rand_word(), rand_word());
        end
      end
    end
    no_idle = 1'b0;

    // drain: let the count catch up with the last request, then wait it out
    in_valid <= 1'b0;
    @(posedge clk);
    while (draws_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
